FILE: design/cpt_pkg.sv
// ----------------------------------------------------------------------------
// Capture-period tachometer package
// Widths, reset values, register indexes and state encoding shared by the
// tachometer's modules.
// ----------------------------------------------------------------------------
package cpt_pkg;

   // Configuration register widths and reset values.
   localparam int CLOCK_HZ_W       = 27;
   localparam int PRESCALE_W       = 9;
   localparam int CSR_DATA_W       = 27;
   localparam int CSR_INDEX_W      = 2;
   localparam logic [CLOCK_HZ_W-1:0] CLOCK_HZ_RESET = CLOCK_HZ_W'(10000000);
   localparam logic [PRESCALE_W-1:0] PRESCALE_RESET = PRESCALE_W'(256);

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_CLOCK_HZ = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESCALE = CSR_INDEX_W'(1);

   // Result format.
   localparam int SPEED_W         = 40;
   localparam int SPEED_FRAC_BITS = 8;

   // Parameter defaults.
   localparam int HISTORY_DEPTH_DEFAULT = 16;
   localparam int STAMP_WIDTH_DEFAULT   = 16;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_MUL,
      ST_START,
      ST_DIV,
      ST_RESULT
   } state_type;

   // Status of the serial divider.
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

FILE: design/cpt_history.sv
// ----------------------------------------------------------------------------
// Period history
// Shift line of the most recent periods with a running sum of its contents.
// ----------------------------------------------------------------------------
module cpt_history #(
   parameter int HISTORY_DEPTH = cpt_pkg::HISTORY_DEPTH_DEFAULT,
   parameter int STAMP_WIDTH   = cpt_pkg::STAMP_WIDTH_DEFAULT,
   parameter int SUM_W         = STAMP_WIDTH + $clog2(HISTORY_DEPTH)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   shift_en,
   input  logic [STAMP_WIDTH-1:0] period,
   output logic [SUM_W-1:0]       sum
);

   logic [STAMP_WIDTH-1:0] hist_ff [HISTORY_DEPTH];
   logic [STAMP_WIDTH-1:0] hist_in [HISTORY_DEPTH];
   logic [SUM_W-1:0]       sum_ff;
   logic [SUM_W-1:0]       sum_in;

   always_comb begin
      hist_in[0] = period;
      for (int i = 1; i < HISTORY_DEPTH; i++) begin
         hist_in[i] = hist_ff[i-1];
      end
      // The oldest period leaves as the newest one enters.
      sum_in = sum_ff - SUM_W'(hist_ff[HISTORY_DEPTH-1]) + SUM_W'(period);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            hist_ff[i] <= '0;
         end
         sum_ff <= '0;
      end else if (shift_en) begin
         hist_ff <= hist_in;
         sum_ff  <= sum_in;
      end
   end

   assign sum = sum_ff;

endmodule

FILE: design/cpt_divider.sv
// ----------------------------------------------------------------------------
// Serial divider
// Restoring division, one quotient bit per cycle. The denominator must stay
// stable while the division runs.
// ----------------------------------------------------------------------------
module cpt_divider #(
   parameter int NUM_W = 40,
   parameter int DEN_W = 29
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [NUM_W-1:0]       numerator,
   input  logic [DEN_W-1:0]       denominator,
   output cpt_pkg::div_status_type status,
   output logic [NUM_W-1:0]       quotient
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] work_ff, work_in;
   logic [DEN_W:0]   partial;
   logic [DEN_W:0]   diff;
   logic             fits;

   always_comb begin
      partial  = {rem_ff, work_ff[NUM_W-1]};
      fits     = partial >= {1'b0, denominator};
      diff     = partial - {1'b0, denominator};
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      work_in  = work_ff;
      if (start) begin
         // The work register holds the numerator bits still to be brought
         // down, and fills with quotient bits from the bottom.
         busy_in  = 1'b1;
         count_in = CNT_W'(NUM_W);
         rem_in   = '0;
         work_in  = numerator;
      end else if (busy_ff) begin
         rem_in   = fits ? diff[DEN_W-1:0] : partial[DEN_W-1:0];
         work_in  = {work_ff[NUM_W-2:0], fits};
         count_in = count_ff - CNT_W'(1);
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff  <= rem_in;
      work_ff <= work_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = work_ff;

endmodule

FILE: design/capture_period_tachometer.sv
// ----------------------------------------------------------------------------
// Capture-period tachometer
// Each request transaction carries one timer stamp captured at an encoder
// edge. The block takes the wrapped difference to the previous stamp as the
// edge period, keeps the last HISTORY_DEPTH periods (cleared at reset) with
// their sum, and answers with one response transaction carrying the speed in
// revolutions per second as unsigned Q.8:
// floor(256 * HISTORY_DEPTH * clock_hz / (sum * prescale)). A zero divisor,
// or a quotient beyond 40 bits, gives the all-ones speed with saturated set.
// The response is registered after the shift, multiply, start, divide and
// result states; in the divide state the serial divider resolves one
// quotient bit per cycle of the numerator, NUM_W = 35 + clog2(HISTORY_DEPTH
// + 1) bits wide. A new stamp can be taken as soon as the response is
// valid. A zero divisor skips the divider, going from the start state
// straight to the result state. Only one stamp is in work at a time; the
// response sits in an output register, so a new stamp is taken while the
// previous response waits. Register writes are taken at any time but must
// be issued only while the block is idle.
// ----------------------------------------------------------------------------
module capture_period_tachometer #(
   parameter int HISTORY_DEPTH = cpt_pkg::HISTORY_DEPTH_DEFAULT,
   parameter int STAMP_WIDTH   = cpt_pkg::STAMP_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // Configuration port.
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [cpt_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [cpt_pkg::CSR_DATA_W-1:0]   csr_data,
   // Request channel.
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [STAMP_WIDTH-1:0]           req_stamp,
   // Response channel.
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [cpt_pkg::SPEED_W-1:0]      rsp_speed_q8,
   output logic                             rsp_saturated
);

   // Running sum of the history, and the divisor sum * prescale.
   localparam int SUM_W   = STAMP_WIDTH + $clog2(HISTORY_DEPTH);
   localparam int DEN_W   = SUM_W + cpt_pkg::PRESCALE_W;
   // Numerator clock_hz * 256 * HISTORY_DEPTH.
   localparam int SCALE_W = cpt_pkg::SPEED_FRAC_BITS + $clog2(HISTORY_DEPTH + 1);
   localparam int SCALE   = (1 << cpt_pkg::SPEED_FRAC_BITS) * HISTORY_DEPTH;
   localparam int NUM_W   = cpt_pkg::CLOCK_HZ_W + SCALE_W;
   // Quotient compared against the largest speed at the wider of the two.
   localparam int QX_W    = (NUM_W > cpt_pkg::SPEED_W) ? NUM_W : cpt_pkg::SPEED_W;

   cpt_pkg::state_type state_ff, state_in;

   logic [cpt_pkg::CLOCK_HZ_W-1:0] clock_hz_ff;
   logic [cpt_pkg::PRESCALE_W-1:0] prescale_ff;
   logic [STAMP_WIDTH-1:0]         last_stamp_ff;
   logic [STAMP_WIDTH-1:0]         period_ff;
   logic [DEN_W-1:0]               den_ff;
   logic [NUM_W-1:0]               num_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [cpt_pkg::SPEED_W-1:0]    rsp_speed_q8_ff, rsp_speed_q8_in;
   logic                           rsp_saturated_ff, rsp_saturated_in;

   logic                    req_take;
   logic                    out_free;
   logic                    shift_en;
   logic                    div_start;
   logic                    den_zero;
   logic                    clipped;
   logic [SUM_W-1:0]        period_sum;
   logic [NUM_W-1:0]        quotient;
   logic [QX_W-1:0]         quotient_ext;
   cpt_pkg::div_status_type div_status;

   // ---------------------------------------------------------------------
   // Configuration registers. The port never stalls; writes to an index
   // other than the two registers are dropped.
   // ---------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_hz_ff <= cpt_pkg::CLOCK_HZ_RESET;
         prescale_ff <= cpt_pkg::PRESCALE_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == cpt_pkg::CSR_CLOCK_HZ) begin
            clock_hz_ff <= csr_data[cpt_pkg::CLOCK_HZ_W-1:0];
         end else if (csr_index == cpt_pkg::CSR_PRESCALE) begin
            prescale_ff <= csr_data[cpt_pkg::PRESCALE_W-1:0];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Period capture. The difference wraps modulo 2^STAMP_WIDTH, so a timer
   // rollover between successive encoder edges still yields the true period.
   // After reset the previous stamp reads as zero.
   // ---------------------------------------------------------------------
   assign req_ready = (state_ff == cpt_pkg::ST_IDLE);
   assign req_take  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_stamp_ff <= '0;
      end else if (req_take) begin
         last_stamp_ff <= req_stamp;
      end
      if (req_take) begin
         period_ff <= req_stamp - last_stamp_ff;
      end
   end

   // History shift line and running sum, advanced once per stamp.
   assign shift_en = (state_ff == cpt_pkg::ST_SHIFT);

   cpt_history #(
      .HISTORY_DEPTH(HISTORY_DEPTH),
      .STAMP_WIDTH  (STAMP_WIDTH),
      .SUM_W        (SUM_W)
   ) u_history (
      .clock   (clock),
      .reset   (reset),
      .shift_en(shift_en),
      .period  (period_ff),
      .sum     (period_sum)
   );

   // ---------------------------------------------------------------------
   // Operand preparation. The divisor is a narrow product (sum times a
   // 9-bit prescale); the numerator is the clock scaled by a constant.
   // Both are registered before the divider starts.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (state_ff == cpt_pkg::ST_MUL) begin
         den_ff <= DEN_W'(period_sum) * DEN_W'(prescale_ff);
         num_ff <= NUM_W'(clock_hz_ff) * NUM_W'(SCALE);
      end
   end

   assign den_zero  = (den_ff == '0);
   assign div_start = (state_ff == cpt_pkg::ST_START) && !den_zero;

   cpt_divider #(
      .NUM_W(NUM_W),
      .DEN_W(DEN_W)
   ) u_divider (
      .clock      (clock),
      .reset      (reset),
      .start      (div_start),
      .numerator  (num_ff),
      .denominator(den_ff),
      .status     (div_status),
      .quotient   (quotient)
   );

   // Clip the quotient to the 40-bit speed field.
   assign quotient_ext = QX_W'(quotient);
   assign clipped      = quotient_ext > QX_W'({cpt_pkg::SPEED_W{1'b1}});

   // ---------------------------------------------------------------------
   // Sequencer and response register. The response register frees as the
   // waiting response transaction completes, in the same cycle.
   // ---------------------------------------------------------------------
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in         = state_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_speed_q8_in  = rsp_speed_q8_ff;
      rsp_saturated_in = rsp_saturated_ff;
      case (state_ff)
         cpt_pkg::ST_IDLE: begin
            if (req_take) begin
               state_in = cpt_pkg::ST_SHIFT;
            end
         end
         cpt_pkg::ST_SHIFT: begin
            state_in = cpt_pkg::ST_MUL;
         end
         cpt_pkg::ST_MUL: begin
            state_in = cpt_pkg::ST_START;
         end
         cpt_pkg::ST_START: begin
            // A zero divisor needs no division.
            state_in = den_zero ? cpt_pkg::ST_RESULT : cpt_pkg::ST_DIV;
         end
         cpt_pkg::ST_DIV: begin
            if (div_status.done) begin
               state_in = cpt_pkg::ST_RESULT;
            end
         end
         cpt_pkg::ST_RESULT: begin
            if (out_free) begin
               state_in     = cpt_pkg::ST_IDLE;
               rsp_valid_in = 1'b1;
               if (den_zero || clipped) begin
                  rsp_speed_q8_in  = {cpt_pkg::SPEED_W{1'b1}};
                  rsp_saturated_in = 1'b1;
               end else begin
                  rsp_speed_q8_in  = quotient_ext[cpt_pkg::SPEED_W-1:0];
                  rsp_saturated_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = cpt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cpt_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_speed_q8_ff  <= rsp_speed_q8_in;
      rsp_saturated_ff <= rsp_saturated_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_speed_q8  = rsp_speed_q8_ff;
   assign rsp_saturated = rsp_saturated_ff;

`ifndef SYNTH
   // The divider is never busy while a new stamp can be taken.
   assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !div_status.busy)
      else $error("divider busy while the block is ready for a stamp");

   // A new response is loaded only when leaving the result state.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff || rsp_ready) ##1 rsp_valid_ff
         |-> $past(state_ff) == cpt_pkg::ST_RESULT)
      else $error("response loaded outside the result state");

   // A zero divisor always gives the saturated all-ones speed.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == cpt_pkg::ST_RESULT && out_free && den_zero
         |=> rsp_valid_ff && rsp_saturated_ff && (&rsp_speed_q8_ff))
      else $error("zero divisor did not saturate the speed");

   // The divider reports completion only while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> state_ff == cpt_pkg::ST_DIV)
      else $error("divider finished outside the divide state");
`endif

endmodule
